/* hw/rtl/lldq_pkg.sv */
// ----------------------------------------------------------------------------
// lldq_pkg: shared types and constants
// Node pool sizing, opcodes, status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lldq_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_REM_HEAD = 3'd2,
        OP_REM_TAIL = 3'd3,
        OP_DELETE   = 3'd4,
        OP_REPLACE  = 3'd5,
        OP_SEARCH   = 3'd6,
        OP_UNUSED   = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISS    = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_INS,
        S_UNLINK_RD,
        S_UNLINK_WR,
        S_WALK_RD,
        S_WALK_CHK,
        S_HEADRD,
        S_TAILRD,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;      // capture input item
        logic init_clear;    // chain one free entry (init_reg)
        logic do_insert;     // link a new node at head or tail
        logic start_unlink;  // set victim from head/tail/walk cursor
        logic unlink_rd;     // read victim's links registered
        logic unlink_wr;     // relink neighbors, free victim
        logic walk_start;    // load cursor with head and counter
        logic walk_rd;       // read cursor node
        logic walk_adv;      // advance cursor
        logic rep_wr;        // write new value at cursor
        logic head_rd;       // read head value
        logic tail_rd;       // read tail value
        logic set_done;      // status done
        logic set_full;      // status full
        logic clear_stat;    // status miss
        logic victim_tail;   // 1: victim is tail, 0: head (for removes)
        logic victim_cur;    // victim is walk cursor
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t op;
        logic    every;
        logic    full;
        logic    empty;
        logic    match;
        logic    walk_last;
        logic    walk_done;
        logic    init_last;
    } stat_t;

endpackage

/* hw/rtl/linked_list_deque_with_search.sv */
// ----------------------------------------------------------------------------
// Sequence: an insert passes through S_INS, S_HEADRD, S_TAILRD and S_OUT; a
// remove adds S_UNLINK_RD and S_UNLINK_WR; delete/replace/search read and check
// nodes in turn in S_WALK_RD and S_WALK_CHK, with an unlink pair per deleted node.
// Commands are taken one at a time, in S_IDLE after the result is loaded and
// only while the result register is empty or read. Reset: asynchronous; an init
// pass chains the free list before the first transfer is taken.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// linked_list_deque_with_search: bounded doubly linked list engine
// Controller and node-pool datapath with a registered result stage.
// ----------------------------------------------------------------------------
module linked_list_deque_with_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] value,
    input  logic signed [31:0] new_value,
    input  logic               every_match,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [6:0]         element_total,
    output logic signed [31:0] first_value,
    output logic signed [31:0] last_value,
    output logic               list_empty
);

    lldq_pkg::cmd_t     cmd;
    lldq_pkg::stat_t    st;
    logic               out_load;
    logic [1:0]         res_status;
    lldq_pkg::count_t   res_total;
    logic signed [31:0] res_first, res_last;
    logic               out_valid_reg;

    lldq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid_reg),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd),
        .out_load  (out_load)
    );

    lldq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .opcode      (opcode),
        .value       (value),
        .new_value   (new_value),
        .every_match (every_match),
        .res_status  (res_status),
        .res_total   (res_total),
        .res_first   (res_first),
        .res_last    (res_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status        <= res_status;
            element_total <= 7'(res_total);
            first_value   <= res_first;
            last_value    <= res_last;
            list_empty    <= (res_total == '0);
        end
    end

    assign out_valid = out_valid_reg;

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (element_total <= 7'd64))
        else $error("element total out of range");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && list_empty) |-> (first_value == 0 && last_value == 0))
        else $error("empty list with nonzero values");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (list_empty == (element_total == 7'd0)))
        else $error("empty flag mismatch");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

endmodule

/* hw/rtl/lldq_ctrl.sv */
// ----------------------------------------------------------------------------
// lldq_ctrl: command sequencer
// Steps through the pool init after reset, then each command through insert, unlink and list walks.
// ----------------------------------------------------------------------------
module lldq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  lldq_pkg::stat_t    st,
    output lldq_pkg::cmd_t     cmd,
    output logic               out_load
);

    lldq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lldq_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            lldq_pkg::S_INIT:
            begin
                cmd.init_clear = 1'b1;
                if (st.init_last)
                begin
                    state_next = lldq_pkg::S_IDLE;
                end
            end
            lldq_pkg::S_IDLE:
            begin
                in_ready = !out_valid || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = lldq_pkg::S_INS;
                end
            end
            lldq_pkg::S_INS:
            begin
                cmd.clear_stat = 1'b1;
                state_next     = lldq_pkg::S_HEADRD;
                unique case (st.op) inside
                    lldq_pkg::OP_INS_HEAD, lldq_pkg::OP_INS_TAIL:
                    begin
                        if (st.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.do_insert = 1'b1;
                            cmd.set_done  = 1'b1;
                        end
                    end
                    lldq_pkg::OP_REM_HEAD, lldq_pkg::OP_REM_TAIL:
                    begin
                        if (!st.empty)
                        begin
                            cmd.start_unlink = 1'b1;
                            cmd.victim_tail  = (st.op == lldq_pkg::OP_REM_TAIL);
                            cmd.set_done     = 1'b1;
                            state_next       = lldq_pkg::S_UNLINK_RD;
                        end
                    end
                    lldq_pkg::OP_DELETE, lldq_pkg::OP_REPLACE, lldq_pkg::OP_SEARCH:
                    begin
                        if (!st.empty)
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = lldq_pkg::S_WALK_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lldq_pkg::S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = lldq_pkg::S_WALK_CHK;
            end
            lldq_pkg::S_WALK_CHK:
            begin
                // advance the cursor with the check
                cmd.walk_adv = 1'b1;
                state_next   = st.walk_last ? lldq_pkg::S_HEADRD : lldq_pkg::S_WALK_RD;
                if (st.match)
                begin
                    cmd.set_done = 1'b1;
                    if (st.op == lldq_pkg::OP_DELETE)
                    begin
                        cmd.start_unlink = 1'b1;
                        cmd.victim_cur   = 1'b1;
                        state_next       = lldq_pkg::S_UNLINK_RD;
                    end
                    else if (st.op == lldq_pkg::OP_REPLACE)
                    begin
                        cmd.rep_wr = 1'b1;
                    end
                    if (!st.every || st.op == lldq_pkg::OP_SEARCH)
                    begin
                        if (st.op != lldq_pkg::OP_DELETE)
                        begin
                            state_next = lldq_pkg::S_HEADRD;
                        end
                    end
                end
            end
            lldq_pkg::S_UNLINK_RD:
            begin
                cmd.unlink_rd = 1'b1;
                state_next    = lldq_pkg::S_UNLINK_WR;
            end
            lldq_pkg::S_UNLINK_WR:
            begin
                cmd.unlink_wr = 1'b1;
                if ((st.op == lldq_pkg::OP_DELETE) && st.every && !st.walk_done)
                begin
                    state_next = lldq_pkg::S_WALK_RD;
                end
                else
                begin
                    state_next = lldq_pkg::S_HEADRD;
                end
            end
            lldq_pkg::S_HEADRD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = lldq_pkg::S_TAILRD;
            end
            lldq_pkg::S_TAILRD:
            begin
                cmd.tail_rd = 1'b1;
                state_next  = lldq_pkg::S_OUT;
            end
            lldq_pkg::S_OUT:
            begin
                out_load   = 1'b1;
                state_next = lldq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lldq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lldq_dp.sv */
// ----------------------------------------------------------------------------
// lldq_dp: node pool datapath
// Value and link memories, head/tail/free pointers, count and walk cursor.
// ----------------------------------------------------------------------------
module lldq_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lldq_pkg::cmd_t         cmd,
    output lldq_pkg::stat_t        st,
    input  logic [2:0]             opcode,
    input  logic signed [31:0]     value,
    input  logic signed [31:0]     new_value,
    input  logic                   every_match,
    output logic [1:0]             res_status,
    output lldq_pkg::count_t       res_total,
    output logic signed [31:0]     res_first,
    output logic signed [31:0]     res_last
);

    logic signed [31:0] val_mem [lldq_pkg::CAPACITY];
    lldq_pkg::slot_t    fwd_mem [lldq_pkg::CAPACITY];
    lldq_pkg::slot_t    bwd_mem [lldq_pkg::CAPACITY];

    lldq_pkg::opcode_t  op_reg;
    logic               every_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] newv_reg;
    lldq_pkg::slot_t    head_reg, tail_reg, free_reg;
    lldq_pkg::count_t   count_reg;
    lldq_pkg::slot_t    cur_reg, victim_reg;
    lldq_pkg::slot_t    vprev_reg, vnext_reg;
    lldq_pkg::count_t   left_reg;
    logic signed [31:0] rd_val_reg;
    lldq_pkg::slot_t    rd_fwd_reg;
    lldq_pkg::slot_t    init_reg;
    lldq_pkg::status_t  status_reg;
    logic signed [31:0] first_reg, last_reg;

    logic               empty;

    assign empty        = (count_reg == '0);
    assign st.op        = op_reg;
    assign st.every     = every_reg;
    assign st.full      = (count_reg == lldq_pkg::count_t'(lldq_pkg::CAPACITY));
    assign st.empty     = empty;
    assign st.match     = (rd_val_reg == value_reg);
    assign st.walk_last = (left_reg == lldq_pkg::count_t'(1)) || (left_reg == '0);
    assign st.walk_done = (left_reg == '0);
    assign st.init_last = (init_reg == lldq_pkg::slot_t'(lldq_pkg::CAPACITY - 1));

    assign res_status = status_reg;
    assign res_total  = count_reg;
    assign res_first  = first_reg;
    assign res_last   = last_reg;

    // memories: all writes here; the free-list pop reads fwd_mem in the pointer block
    always_ff @(posedge clk)
    begin
        if (cmd.init_clear)
        begin
            fwd_mem[init_reg] <= init_reg + lldq_pkg::slot_t'(1);
        end
        if (cmd.do_insert)
        begin
            val_mem[free_reg] <= value_reg;
            if (op_reg == lldq_pkg::OP_INS_HEAD)
            begin
                fwd_mem[free_reg] <= head_reg;
            end
            else
            begin
                bwd_mem[free_reg] <= tail_reg;
            end
        end
        if (cmd.do_insert && !empty)
        begin
            if (op_reg == lldq_pkg::OP_INS_HEAD)
            begin
                bwd_mem[head_reg] <= free_reg;
            end
            else
            begin
                fwd_mem[tail_reg] <= free_reg;
            end
        end
        if (cmd.rep_wr)
        begin
            val_mem[cur_reg] <= newv_reg;
        end
        if (cmd.unlink_rd)
        begin
            vprev_reg <= bwd_mem[victim_reg];
            vnext_reg <= fwd_mem[victim_reg];
        end
        if (cmd.unlink_wr)
        begin
            fwd_mem[victim_reg] <= free_reg;
            if (victim_reg != head_reg)
            begin
                fwd_mem[vprev_reg] <= vnext_reg;
            end
            if (victim_reg != tail_reg)
            begin
                bwd_mem[vnext_reg] <= vprev_reg;
            end
        end
        if (cmd.walk_rd)
        begin
            rd_val_reg <= val_mem[cur_reg];
            rd_fwd_reg <= fwd_mem[cur_reg];
        end
        if (cmd.head_rd)
        begin
            first_reg <= empty ? 32'sd0 : val_mem[head_reg];
        end
        if (cmd.tail_rd)
        begin
            last_reg <= empty ? 32'sd0 : val_mem[tail_reg];
        end
        if (cmd.latch_in)
        begin
            op_reg    <= lldq_pkg::opcode_t'(opcode);
            every_reg <= every_match;
            value_reg <= value;
            newv_reg  <= new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            init_reg   <= '0;
            status_reg <= lldq_pkg::ST_MISS;
            cur_reg    <= '0;
            victim_reg <= '0;
            left_reg   <= '0;
        end
        else
        begin
            if (cmd.init_clear)
            begin
                init_reg <= init_reg + lldq_pkg::slot_t'(1);
            end
            if (cmd.clear_stat)
            begin
                status_reg <= lldq_pkg::ST_MISS;
            end
            if (cmd.set_full)
            begin
                status_reg <= lldq_pkg::ST_FULL;
            end
            if (cmd.set_done)
            begin
                status_reg <= lldq_pkg::ST_DONE;
            end
            if (cmd.do_insert)
            begin
                free_reg  <= fwd_mem[free_reg];
                count_reg <= count_reg + lldq_pkg::count_t'(1);
                if (empty || op_reg == lldq_pkg::OP_INS_HEAD)
                begin
                    head_reg <= free_reg;
                end
                if (empty || op_reg == lldq_pkg::OP_INS_TAIL)
                begin
                    tail_reg <= free_reg;
                end
            end
            if (cmd.walk_start)
            begin
                cur_reg  <= head_reg;
                left_reg <= count_reg;
            end
            if (cmd.walk_adv)
            begin
                cur_reg  <= rd_fwd_reg;
                left_reg <= left_reg - lldq_pkg::count_t'(1);
            end
            if (cmd.start_unlink)
            begin
                if (cmd.victim_cur)
                begin
                    victim_reg <= cur_reg;
                end
                else
                begin
                    victim_reg <= cmd.victim_tail ? tail_reg : head_reg;
                end
            end
            if (cmd.unlink_wr)
            begin
                free_reg  <= victim_reg;
                count_reg <= count_reg - lldq_pkg::count_t'(1);
                if (victim_reg == head_reg)
                begin
                    head_reg <= vnext_reg;
                end
                if (victim_reg == tail_reg)
                begin
                    tail_reg <= vprev_reg;
                end
            end
        end
    end

endmodule
